// File: hw/rtl/mtstk_pkg.sv
`timescale 1ns / 1ps

package mtstk_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 8;
    localparam int DEPTH_W     = 7;
    localparam int STATUS_W    = 2;
    localparam int MODE_W      = 2;

    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_FETCH = 2'b10
    } state_t;

    typedef struct packed {
        logic accept;
        logic fetch;
    } dp_cmd_t;

    typedef struct packed {
        logic pop_ok;
    } dp_status_t;

endpackage

// File: hw/rtl/min_tracking_stack.sv
`timescale 1ns / 1ps

// channel | direction | tdata fields (lowest bit up)
// s_*     | in        | mode[1:0], value[9:2], zero pad [15:10]
// m_*     | out       | popped_value[7:0], top_value[15:8], min_value[23:16],
//         |           | depth[30:24], status[32:31], zero pad [39:33]
//
// push, read and rejected requests give their result in the cycle after accept
// a successful pop goes through the fetch state before its result: the new top and
// minimum come from the registered read ports of the item and minimum memories
// a new request is taken in the cycle the pending result leaves
// reset clears counts, flags and control state; memory contents are never cleared
// a stalled result holds; input is refused until it is taken

module min_tracking_stack
    import mtstk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // mode, value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // popped_value, top_value, min_value, depth, status
);

    dp_cmd_t                  dp_cmd;
    dp_status_t               dp_status;
    logic signed [DATA_W-1:0] popped_value, top_value, min_value;
    logic [DEPTH_W-1:0]       depth;
    logic [STATUS_W-1:0]      status;

    mtstk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    mtstk_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .dp_cmd       (dp_cmd),
        .dp_status    (dp_status),
        .mode         (s_tdata[1:0]),
        .value        (s_tdata[9:2]),
        .popped_value (popped_value),
        .top_value    (top_value),
        .min_value    (min_value),
        .depth        (depth),
        .status       (status)
    );

    assign m_tdata = {7'd0, status, depth, min_value, top_value, popped_value};

    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("request accepted while result stalled");

    a_fetch_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.fetch |=> m_tvalid)
        else $error("pop fetch did not produce a result");

    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.accept && !dp_status.pop_ok) |=> m_tvalid)
        else $error("single cycle request gave no result");

    a_pop_fetches: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.accept && dp_status.pop_ok) |=> (dp_cmd.fetch && !s_tready))
        else $error("pop not followed by fetch");

endmodule

// File: hw/rtl/mtstk_ram.sv
`timescale 1ns / 1ps

module mtstk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/mtstk_ctrl.sv
`timescale 1ns / 1ps

module mtstk_ctrl
    import mtstk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t dp_status,
    output dp_cmd_t    dp_cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    assign dp_cmd.accept = accept;
    assign dp_cmd.fetch  = (state_reg == S_FETCH);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (dp_status.pop_ok)
                    begin
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            S_FETCH:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hw/rtl/mtstk_dp.sv
`timescale 1ns / 1ps

module mtstk_dp
    import mtstk_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dp_cmd_t                    dp_cmd,
    output dp_status_t                 dp_status,
    input  logic [MODE_W-1:0]          mode,
    input  logic signed [DATA_W-1:0]   value,
    output logic signed [DATA_W-1:0]   popped_value,
    output logic signed [DATA_W-1:0]   top_value,
    output logic signed [DATA_W-1:0]   min_value,
    output logic [DEPTH_W-1:0]         depth,
    output logic [STATUS_W-1:0]        status
);

    logic [CNT_W-1:0]          item_count_reg, item_count_next;
    logic [CNT_W-1:0]          min_count_reg, min_count_next;
    logic signed [DATA_W-1:0]  top_reg, top_next;
    logic signed [DATA_W-1:0]  min_reg, min_next;
    logic signed [DATA_W-1:0]  popped_reg, popped_next;
    logic [STATUS_W-1:0]       status_reg, status_next;
    logic                      min_popped_reg, min_popped_next;

    logic                      is_push, is_pop, full, empty;
    logic                      push_ok, min_push;
    logic                      item_we, min_we;
    logic [DATA_W-1:0]         item_rdata, min_rdata;

    assign is_push = (mode == MODE_PUSH);
    assign is_pop  = (mode == MODE_POP);
    assign full    = (item_count_reg >= CNT_W'(STACK_DEPTH));
    assign empty   = (item_count_reg == '0);
    assign push_ok = is_push && !full;
    assign min_push = push_ok &&
        ((min_count_reg == '0) ||
         ((min_count_reg < CNT_W'(STACK_DEPTH)) && (value <= min_reg)));

    assign dp_status.pop_ok = is_pop && !empty;

    assign item_we = dp_cmd.accept && push_ok;
    assign min_we  = dp_cmd.accept && min_push;

    // read addresses point one below the current top, the new top after a pop
    mtstk_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_item_ram (
        .clk   (clk),
        .we    (item_we),
        .waddr (ADDR_W'(item_count_reg)),
        .wdata (value),
        .raddr (ADDR_W'(item_count_reg - CNT_W'(2))),
        .rdata (item_rdata)
    );

    mtstk_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_min_ram (
        .clk   (clk),
        .we    (min_we),
        .waddr (ADDR_W'(min_count_reg)),
        .wdata (value),
        .raddr (ADDR_W'(min_count_reg - CNT_W'(2))),
        .rdata (min_rdata)
    );

    always_comb
    begin
        item_count_next = item_count_reg;
        min_count_next  = min_count_reg;
        top_next        = top_reg;
        min_next        = min_reg;
        popped_next     = popped_reg;
        status_next     = status_reg;
        min_popped_next = min_popped_reg;
        if (dp_cmd.accept)
        begin
            popped_next     = '0;
            status_next     = ST_OK;
            min_popped_next = 1'b0;
            if (is_push)
            begin
                if (full)
                begin
                    status_next = ST_OVER;
                end
                else
                begin
                    item_count_next = item_count_reg + CNT_W'(1);
                    top_next        = value;
                    if (min_push)
                    begin
                        min_count_next = min_count_reg + CNT_W'(1);
                        min_next       = value;
                    end
                end
            end
            else if (is_pop)
            begin
                if (empty)
                begin
                    status_next = ST_UNDER;
                end
                else
                begin
                    item_count_next = item_count_reg - CNT_W'(1);
                    popped_next     = top_reg;
                    if ((min_count_reg != '0) && (top_reg == min_reg))
                    begin
                        min_count_next  = min_count_reg - CNT_W'(1);
                        min_popped_next = 1'b1;
                    end
                end
            end
        end
        if (dp_cmd.fetch)
        begin
            top_next = item_rdata;
            if (min_popped_reg)
            begin
                min_next = min_rdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_count_reg <= '0;
            min_count_reg  <= '0;
            min_popped_reg <= 1'b0;
        end
        else
        begin
            item_count_reg <= item_count_next;
            min_count_reg  <= min_count_next;
            min_popped_reg <= min_popped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        min_reg    <= min_next;
        popped_reg <= popped_next;
        status_reg <= status_next;
    end

    assign popped_value = popped_reg;
    assign top_value    = empty ? '0 : top_reg;
    assign min_value    = (empty || (min_count_reg == '0)) ? '0 : min_reg;
    assign depth        = DEPTH_W'(item_count_reg);
    assign status       = status_reg;

endmodule

// File: bench/tb_min_tracking_stack.sv
`timescale 1ns / 1ps

module tb_min_tracking_stack;
    import mtstk_pkg::*;

    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PHASE_BUDGET  = 190;
    localparam int N_DIRECTED    = 24;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [DEPTH_W-1:0]       depth;
        logic signed [DATA_W-1:0] min_v;
        logic signed [DATA_W-1:0] top;
        logic signed [DATA_W-1:0] popped;
    } stack_view_t;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] value;
        logic                     typed;
        stack_view_t              view;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    logic signed [DATA_W-1:0] held_items  [STACK_DEPTH];
    logic signed [DATA_W-1:0] held_minima [STACK_DEPTH];
    int n_items;
    int n_minima;

    stack_view_t due_views[$];
    stim_row_t   directed_rows [N_DIRECTED];

    int  errors;
    int  n_sent;
    int  n_checked;
    int  n_push;
    int  n_pop;
    int  n_read;
    int  n_over;
    int  n_under;
    int  sender_idle_pct;
    int  stall_pct;
    logic hold_off;

    min_tracking_stack i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic stack_view_t make_view(input int popped,
                                              input int top,
                                              input int min_v,
                                              input int depth,
                                              input logic [STATUS_W-1:0] status);
        stack_view_t v;
        v.popped = popped[DATA_W-1:0];
        v.top    = top[DATA_W-1:0];
        v.min_v  = min_v[DATA_W-1:0];
        v.depth  = depth[DEPTH_W-1:0];
        v.status = status;
        return v;
    endfunction

    function automatic stim_row_t typed_row(input logic [MODE_W-1:0] mode,
                                            input logic signed [DATA_W-1:0] value,
                                            input stack_view_t view);
        stim_row_t r;
        r.mode  = mode;
        r.value = value;
        r.typed = 1'b1;
        r.view  = view;
        return r;
    endfunction

    function automatic stim_row_t plain_row(input logic [MODE_W-1:0] mode,
                                            input logic signed [DATA_W-1:0] value);
        stim_row_t r;
        r.mode  = mode;
        r.value = value;
        r.typed = 1'b0;
        r.view  = '0;
        return r;
    endfunction

    function automatic stack_view_t apply_stack_op(input logic [MODE_W-1:0] mode,
                                                   input logic signed [DATA_W-1:0] value);
        stack_view_t v;
        v = '0;
        v.status = ST_OK;
        if (mode == MODE_PUSH)
        begin
            if (n_items >= STACK_DEPTH)
                v.status = ST_OVER;
            else
            begin
                held_items[n_items] = value;
                n_items++;
                if (n_minima == 0)
                begin
                    held_minima[0] = value;
                    n_minima = 1;
                end
                else if (n_minima < STACK_DEPTH && value <= held_minima[n_minima-1])
                begin
                    held_minima[n_minima] = value;
                    n_minima++;
                end
            end
        end
        else if (mode == MODE_POP)
        begin
            if (n_items == 0)
                v.status = ST_UNDER;
            else
            begin
                n_items--;
                v.popped = held_items[n_items];
                if (n_minima > 0 && v.popped == held_minima[n_minima-1])
                    n_minima--;
            end
        end
        if (n_items > 0)
            v.top = held_items[n_items-1];
        if (n_items > 0 && n_minima > 0)
            v.min_v = held_minima[n_minima-1];
        v.depth = n_items[DEPTH_W-1:0];
        return v;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_value();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25)
            return DATA_W'($signed($urandom_range(8)) - 4);
        else if (pick < 40)
        begin
            case ($urandom_range(3))
                0: return -8'sd128;
                1: return 8'sd127;
                2: return -8'sd1;
                default: return 8'sd0;
            endcase
        end
        return DATA_W'($urandom);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on result %0d: %s got %0d expected %0d", n_checked, what, got, want);
        errors++;
    endtask

    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input logic signed [DATA_W-1:0] value,
                                input logic typed,
                                input stack_view_t typed_view);
        stack_view_t v;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 16'($urandom);
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, value, mode};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        v = apply_stack_op(mode, value);
        due_views.push_back(typed ? typed_view : v);
        n_sent++;
        case (mode)
            MODE_PUSH: n_push++;
            MODE_POP:  n_pop++;
            default:   n_read++;
        endcase
        if (v.status == ST_OVER)
            n_over++;
        if (v.status == ST_UNDER)
            n_under++;
    endtask

    task automatic send_plain(input logic [MODE_W-1:0] mode,
                              input logic signed [DATA_W-1:0] value);
        send_request(mode, value, 1'b0, '0);
    endtask

    task automatic fill_stack();
        while (n_items < STACK_DEPTH)
            send_plain(MODE_PUSH, rand_value());
        repeat (2)
            send_plain(MODE_PUSH, rand_value());
    endtask

    task automatic drain_stack();
        while (n_items > 0)
            send_plain(MODE_POP, DATA_W'($urandom));
        repeat (2)
            send_plain(MODE_POP, DATA_W'($urandom));
    endtask

    task automatic send_mixed(input int push_pct, input int count);
        int pick;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < push_pct)
                send_plain(MODE_PUSH, rand_value());
            else if (pick < 90)
                send_plain(MODE_POP, DATA_W'($urandom));
            else if (pick < 96)
                send_plain(MODE_READ, DATA_W'($urandom));
            else
                send_plain(MODE_SPARE, DATA_W'($urandom));
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_in_pct);
        int start;
        sender_idle_pct = idle_pct;
        stall_pct       = stall_in_pct;
        start = n_sent;
        fill_stack();
        while (n_sent - start < PHASE_BUDGET - 70)
        begin
            case ($urandom_range(2))
                0: send_mixed(25, 16);
                1: send_mixed(50, 16);
                default: send_mixed(75, 16);
            endcase
        end
        drain_stack();
    endtask

    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                hold_done = 1'b1;
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        stack_view_t got;
        stack_view_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = stack_view_t'(m_tdata[32:0]);
            if (due_views.size() == 0)
                report_mismatch("outstanding requests", 0, 1);
            else
            begin
                want = due_views.pop_front();
                if (got.popped !== want.popped)
                    report_mismatch("popped_value", int'(got.popped), int'(want.popped));
                if (got.top !== want.top)
                    report_mismatch("top_value", int'(got.top), int'(want.top));
                if (got.min_v !== want.min_v)
                    report_mismatch("min_value", int'(got.min_v), int'(want.min_v));
                if (got.depth !== want.depth)
                    report_mismatch("depth", int'(got.depth), int'(want.depth));
                if (got.status !== want.status)
                    report_mismatch("status", int'(got.status), int'(want.status));
            end
            if (m_tdata[39:33] !== '0)
                report_mismatch("tdata padding", int'(m_tdata[39:33]), 0);
            n_checked++;
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        hold_off <= 1'b0;
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_push = 0;
        n_pop = 0;
        n_read = 0;
        n_over = 0;
        n_under = 0;
        n_items = 0;
        n_minima = 0;
        sender_idle_pct = 0;
        stall_pct = 0;

        directed_rows = '{
            typed_row(MODE_READ,  8'sd0,    make_view(0, 0, 0, 0, ST_OK)),
            typed_row(MODE_POP,   8'sd0,    make_view(0, 0, 0, 0, ST_UNDER)),
            typed_row(MODE_SPARE, -8'sd1,   make_view(0, 0, 0, 0, ST_OK)),
            typed_row(MODE_PUSH,  8'sd127,  make_view(0, 127, 127, 1, ST_OK)),
            typed_row(MODE_PUSH,  -8'sd128, make_view(0, -128, -128, 2, ST_OK)),
            typed_row(MODE_PUSH,  -8'sd128, make_view(0, -128, -128, 3, ST_OK)),
            typed_row(MODE_POP,   8'sd85,   make_view(-128, -128, -128, 2, ST_OK)),
            typed_row(MODE_POP,   8'sd0,    make_view(-128, 127, 127, 1, ST_OK)),
            plain_row(MODE_PUSH,  8'sd0),
            plain_row(MODE_PUSH,  8'sd5),
            plain_row(MODE_PUSH,  8'sd5),
            plain_row(MODE_PUSH,  -8'sd1),
            plain_row(MODE_READ,  8'sd85),
            plain_row(MODE_PUSH,  -8'sd86),
            plain_row(MODE_PUSH,  -8'sd86),
            plain_row(MODE_SPARE, 8'sd0),
            plain_row(MODE_POP,   -8'sd1),
            plain_row(MODE_POP,   8'sd0),
            plain_row(MODE_POP,   8'sd0),
            plain_row(MODE_POP,   8'sd0),
            plain_row(MODE_POP,   8'sd0),
            plain_row(MODE_POP,   8'sd0),
            plain_row(MODE_POP,   8'sd0),
            typed_row(MODE_POP,   8'sd127,  make_view(0, 0, 0, 0, ST_UNDER))
        };

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].mode, directed_rows[i].value,
                         directed_rows[i].typed, directed_rows[i].view);

        run_phase(0, 0);
        run_phase(78, 0);
        run_phase(0, 78);
        run_phase(29, 29);

        // receiver holds off while requests keep coming
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_off <= 1'b1;
        send_mixed(75, 40);
        drain_stack();

        s_tvalid <= 1'b0;
        while (due_views.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("%0d requests, %0d results checked: %0d push, %0d pop, %0d read",
                 n_sent, n_checked, n_push, n_pop, n_read);
        $display("%0d overflow and %0d underflow cases, idle and stall phases plus a long hold-off",
                 n_over, n_under);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
